// ----- rtl/rrts_pkg.sv -----
// Shared constants and codes for the round-robin task scheduler.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package rrts_pkg;

  localparam int TASKS  = 16;
  localparam int SLOT_W = $clog2(TASKS);
  localparam int CUR_W  = $clog2(TASKS + 1);
  localparam int ID_W   = 5;
  localparam int CMP_W  = (CUR_W > ID_W) ? CUR_W : ID_W;

  typedef enum logic [2:0] {
    ST_EMPTY      = 3'd0,
    ST_READY      = 3'd1,
    ST_RUNNING    = 3'd2,
    ST_SLEEPING   = 3'd3,
    ST_WAITING    = 3'd4,
    ST_TERMINATED = 3'd5
  } slot_state_e;

  typedef enum logic [2:0] {
    ACT_CREATE    = 3'd0,
    ACT_BLOCK     = 3'd1,
    ACT_UNBLOCK   = 3'd2,
    ACT_TERMINATE = 3'd3,
    ACT_YIELD     = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    STS_OK          = 2'd0,
    STS_FULL        = 2'd1,
    STS_UNKNOWN     = 2'd2,
    STS_NOT_BLOCKED = 2'd3
  } status_e;

endpackage

// ----- rtl/rrts_if.sv -----
// Request and response channel interfaces of the task scheduler.
// Depends on rrts_pkg for the id width.
`timescale 1ns / 1ps

interface rrts_req_if import rrts_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [2:0]      action;
  logic            initial_state;
  logic            block_reason;
  logic [ID_W-1:0] task_id;

  modport source (output valid, action, initial_state, block_reason, task_id,
                  input ready);
  modport sink   (input valid, action, initial_state, block_reason, task_id,
                  output ready);
endinterface

interface rrts_rsp_if import rrts_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [1:0]      status;
  logic [ID_W-1:0] running_task;
  logic            switched;
  logic [ID_W-1:0] new_task_id;
  logic [ID_W-1:0] runnable_count;

  modport source (output valid, status, running_task, switched, new_task_id,
                  runnable_count, input ready);
  modport sink   (input valid, status, running_task, switched, new_task_id,
                  runnable_count, output ready);
endinterface

// ----- rtl/round_robin_task_scheduler.sv -----
// Round-robin task scheduler: slot table, sequencer and search stepper.
// Depends on rrts_pkg and the channel interfaces in rrts_if.sv.
//
//   Channel  Direction  Payload
//   req_i    in         action, initial_state, block_reason, task_id
//   rsp_o    out        status, running_task, switched, new_task_id, runnable_count
//
// Each request is handled alone; req_i is ready only while the sequencer waits.
// Create writes its slot at once; unblock reads the target slot, demotes the running
// slot and makes the target run; block and terminate rewrite the running slot, and
// they and yield search the slots, each lookup going through the registered read port.
// Reset marks every slot as unwritten at once, so no clearing pass is needed.
// A result waits in the response register; the next request is accepted meanwhile.
`timescale 1ns / 1ps

module round_robin_task_scheduler import rrts_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  rrts_req_if.sink   req_i,
  rrts_rsp_if.source rsp_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_UB_CHK,
    S_UB_DEM,
    S_UB_RUN,
    S_RS,
    S_RS_DEM,
    S_SR_ADDR,
    S_SR_CHK,
    S_DONE
  } fsm_e;

  localparam logic [CUR_W-1:0] IdleSlot = CUR_W'(TASKS);

  // Slot table with a write port and a registered read port.
  slot_state_e mem_q [TASKS];
  logic [TASKS-1:0] vld_q;
  slot_state_e mem_rd_q;
  logic rd_vld_q, rd_zero_q;

  logic              wr_en, rd_en;
  logic [SLOT_W-1:0] wr_addr, rd_addr;
  slot_state_e       wr_data, st_rd;

  fsm_e state_q, state_d;
  action_e act_q, act_d;
  logic init_q, init_d, reason_q, reason_d;
  logic [ID_W-1:0] tid_q, tid_d, before_q, before_d, new_q, new_d;
  status_e sts_q, sts_d;
  logic [CUR_W-1:0] cur_q, cur_d, used_q, used_d, run_q, run_d;
  logic [CUR_W-1:0] pos_q, pos_d, cnt_q, cnt_d, pos_next;
  logic [SLOT_W-1:0] sel_slot;

  logic            rsp_vld_q, rsp_vld_d;
  status_e         rsp_sts_q, rsp_sts_d;
  logic [ID_W-1:0] rsp_run_q, rsp_run_d, rsp_new_q, rsp_new_d, rsp_cnt_q, rsp_cnt_d;
  logic            rsp_sw_q, rsp_sw_d;

  function automatic logic [ID_W-1:0] run_id(input logic [CUR_W-1:0] cur);
    return (cur == IdleSlot) ? '0 : (ID_W'(cur) + ID_W'(1));
  endfunction

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_rd_q  <= mem_q[rd_addr];
      rd_vld_q  <= vld_q[rd_addr];
      rd_zero_q <= (rd_addr == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en) begin
      vld_q[wr_addr] <= 1'b1;
    end
  end

  // An unwritten slot reads as its reset value: slot 0 running, others empty.
  assign st_rd = rd_vld_q ? mem_rd_q : (rd_zero_q ? ST_RUNNING : ST_EMPTY);

  // Round-robin stepper: one slot down, wrapping to the newest used slot.
  assign pos_next = (pos_q >= IdleSlot || pos_q == '0 || pos_q > used_q) ?
                    (used_q - CUR_W'(1)) : (pos_q - CUR_W'(1));
  assign sel_slot = SLOT_W'(tid_q - ID_W'(1));

  assign req_i.ready = (state_q == S_IDLE);

  always_comb begin
    state_d  = state_q;
    act_d    = act_q;
    init_d   = init_q;
    reason_d = reason_q;
    tid_d    = tid_q;
    before_d = before_q;
    new_d    = new_q;
    sts_d    = sts_q;
    cur_d    = cur_q;
    used_d   = used_q;
    run_d    = run_q;
    pos_d    = pos_q;
    cnt_d    = cnt_q;
    wr_en    = 1'b0;
    wr_addr  = '0;
    wr_data  = ST_EMPTY;
    rd_en    = 1'b0;
    rd_addr  = '0;

    rsp_vld_d = rsp_vld_q && !rsp_o.ready;
    rsp_sts_d = rsp_sts_q;
    rsp_run_d = rsp_run_q;
    rsp_sw_d  = rsp_sw_q;
    rsp_new_d = rsp_new_q;
    rsp_cnt_d = rsp_cnt_q;

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          act_d    = action_e'(req_i.action);
          init_d   = req_i.initial_state;
          reason_d = req_i.block_reason;
          tid_d    = req_i.task_id;
          before_d = run_id(cur_q);
          new_d    = '0;
          sts_d    = STS_OK;
          state_d  = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_DONE;
        case (act_q)
          ACT_CREATE: begin
            if (used_q >= IdleSlot) begin
              sts_d = STS_FULL;
            end else begin
              wr_en   = 1'b1;
              wr_addr = SLOT_W'(used_q);
              wr_data = init_q ? ST_WAITING : ST_READY;
              if (!init_q) begin
                run_d = run_q + CUR_W'(1);
              end
              used_d = used_q + CUR_W'(1);
              new_d  = ID_W'(used_q) + ID_W'(1);
            end
          end
          ACT_BLOCK, ACT_TERMINATE: begin
            if (cur_q != IdleSlot) begin
              wr_en   = 1'b1;
              wr_addr = SLOT_W'(cur_q);
              if (act_q == ACT_TERMINATE) begin
                wr_data = ST_TERMINATED;
              end else begin
                wr_data = reason_q ? ST_WAITING : ST_SLEEPING;
              end
              if (run_q != '0) begin
                run_d = run_q - CUR_W'(1);
              end
              state_d = S_RS;
            end
          end
          ACT_UNBLOCK: begin
            if (tid_q == '0 || CMP_W'(tid_q) > CMP_W'(used_q)) begin
              sts_d = STS_UNKNOWN;
            end else begin
              rd_en   = 1'b1;
              rd_addr = sel_slot;
              state_d = S_UB_CHK;
            end
          end
          ACT_YIELD: state_d = S_RS;
          default:   state_d = S_DONE;
        endcase
      end
      S_UB_CHK: begin
        if (st_rd != ST_SLEEPING && st_rd != ST_WAITING) begin
          sts_d   = STS_NOT_BLOCKED;
          state_d = S_DONE;
        end else begin
          run_d = run_q + CUR_W'(1);
          if (cur_q != IdleSlot) begin
            rd_en   = 1'b1;
            rd_addr = SLOT_W'(cur_q);
            state_d = S_UB_DEM;
          end else begin
            state_d = S_UB_RUN;
          end
        end
      end
      S_UB_DEM: begin
        if (st_rd == ST_RUNNING) begin
          wr_en   = 1'b1;
          wr_addr = SLOT_W'(cur_q);
          wr_data = ST_READY;
        end
        state_d = S_UB_RUN;
      end
      S_UB_RUN: begin
        wr_en   = 1'b1;
        wr_addr = sel_slot;
        wr_data = ST_RUNNING;
        cur_d   = CUR_W'(sel_slot);
        state_d = S_DONE;
      end
      S_RS: begin
        pos_d = cur_q;
        cnt_d = '0;
        if (run_q == '0) begin
          cur_d   = IdleSlot;
          state_d = S_DONE;
        end else if (cur_q != IdleSlot) begin
          rd_en   = 1'b1;
          rd_addr = SLOT_W'(cur_q);
          state_d = S_RS_DEM;
        end else begin
          state_d = S_SR_ADDR;
        end
      end
      S_RS_DEM: begin
        if (st_rd == ST_RUNNING) begin
          wr_en   = 1'b1;
          wr_addr = SLOT_W'(cur_q);
          wr_data = ST_READY;
        end
        state_d = S_SR_ADDR;
      end
      S_SR_ADDR: begin
        rd_en   = 1'b1;
        rd_addr = SLOT_W'(pos_next);
        pos_d   = pos_next;
        cnt_d   = cnt_q + CUR_W'(1);
        state_d = S_SR_CHK;
      end
      S_SR_CHK: begin
        if (st_rd == ST_READY) begin
          wr_en   = 1'b1;
          wr_addr = SLOT_W'(pos_q);
          wr_data = ST_RUNNING;
          cur_d   = pos_q;
          state_d = S_DONE;
        end else if (cnt_q >= used_q) begin
          cur_d   = IdleSlot;
          state_d = S_DONE;
        end else begin
          state_d = S_SR_ADDR;
        end
      end
      S_DONE: begin
        if (!rsp_vld_q || rsp_o.ready) begin
          rsp_vld_d = 1'b1;
          rsp_sts_d = sts_q;
          rsp_run_d = run_id(cur_q);
          rsp_sw_d  = (run_id(cur_q) != before_q);
          rsp_new_d = new_q;
          rsp_cnt_d = ID_W'(run_q);
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      act_q     <= ACT_YIELD;
      init_q    <= 1'b0;
      reason_q  <= 1'b0;
      tid_q     <= '0;
      before_q  <= '0;
      new_q     <= '0;
      sts_q     <= STS_OK;
      cur_q     <= '0;
      used_q    <= CUR_W'(1);
      run_q     <= CUR_W'(1);
      pos_q     <= '0;
      cnt_q     <= '0;
      rsp_vld_q <= 1'b0;
      rsp_sts_q <= STS_OK;
      rsp_run_q <= '0;
      rsp_sw_q  <= 1'b0;
      rsp_new_q <= '0;
      rsp_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      act_q     <= act_d;
      init_q    <= init_d;
      reason_q  <= reason_d;
      tid_q     <= tid_d;
      before_q  <= before_d;
      new_q     <= new_d;
      sts_q     <= sts_d;
      cur_q     <= cur_d;
      used_q    <= used_d;
      run_q     <= run_d;
      pos_q     <= pos_d;
      cnt_q     <= cnt_d;
      rsp_vld_q <= rsp_vld_d;
      rsp_sts_q <= rsp_sts_d;
      rsp_run_q <= rsp_run_d;
      rsp_sw_q  <= rsp_sw_d;
      rsp_new_q <= rsp_new_d;
      rsp_cnt_q <= rsp_cnt_d;
    end
  end

  assign rsp_o.valid          = rsp_vld_q;
  assign rsp_o.status         = rsp_sts_q;
  assign rsp_o.running_task   = rsp_run_q;
  assign rsp_o.switched       = rsp_sw_q;
  assign rsp_o.new_task_id    = rsp_new_q;
  assign rsp_o.runnable_count = rsp_cnt_q;

  // The running slot is either a table slot or the idle marker.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cur_q <= IdleSlot)
    else $error("current slot beyond the idle marker");

  // Slots are handed out in order and the first one always exists.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   used_q >= CUR_W'(1) && used_q <= IdleSlot)
    else $error("slot use count out of range");

  // A request transaction blocks the request channel on the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   req_i.valid && req_i.ready |=> !req_i.ready)
    else $error("request accepted while a previous one is in progress");

  // A new response is only raised on leaving the result state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   $rose(rsp_vld_q) |-> $past(state_q == S_DONE))
    else $error("response raised outside the result state");

endmodule
